// ===== design/qte_pkg.sv =====
// shared widths, constants, types and the arctangent table of the quaternion to euler block
// no dependencies

package qte_pkg;

    // input component width and derived datapath widths
    localparam int CW = 16;
    localparam int PW = 2 * CW;        // one component product
    localparam int SW = PW + 2;        // product sums, doubled cross terms
    localparam int NW = 32;            // reduced norm and numerator for the arcsine path
    localparam int RADW = 2 * NW;      // radicand of the square root
    localparam int ISQ_STEPS = NW;     // one result bit per square-root step
    localparam int CSTAGES = 16;       // cordic micro-rotations
    localparam int CXW = SW + 4;       // cordic x and y, room for gain and pre-rotation
    localparam int ZW = 33;            // angle accumulator, centidegrees with 16 fraction bits
    localparam int ZFRAC = 16;
    localparam int ANG_W = 16;
    localparam int PITCH_W = 15;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);

    // back pipeline depth
    localparam int DL = 3 + ISQ_STEPS;              // up to the square-root result
    localparam int CLAT = CSTAGES + 2;              // cordic: pre-rotation, steps, rounding
    localparam int BACK_LAT = DL + CLAT;

    localparam int OUT_TDATA_W = 48;

    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(589824000);
    localparam logic signed [ZW-1:0] HALF_LSB = ZW'(32768);
    localparam int HALF_TURN_CD = 18000;
    localparam int QUARTER_TURN_CD = 9000;

    // arcsine argument class
    typedef enum logic [1:0] {
        PC_MID = 2'd0,
        PC_POS = 2'd1,
        PC_NEG = 2'd2
    } pitch_class_t;

    typedef struct packed {
        logic signed [SW-1:0] norm;
        logic signed [SW-1:0] num;
        logic signed [SW-1:0] yaw_y;
        logic signed [SW-1:0] yaw_x;
        logic signed [SW-1:0] roll_y;
        logic signed [SW-1:0] roll_x;
    } front_item_t;

    typedef struct packed {
        logic         bad;
        pitch_class_t cls;
    } side_t;

    // round(atan(2^-i) * 18000/pi * 65536)
    function automatic logic signed [ZW-1:0] atan_entry(input int unsigned i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = ZW'(294912000);
            1:  v = ZW'(174096719);
            2:  v = ZW'(91987925);
            3:  v = ZW'(46694507);
            4:  v = ZW'(23437865);
            5:  v = ZW'(11730358);
            6:  v = ZW'(5866610);
            7:  v = ZW'(2933484);
            8:  v = ZW'(1466764);
            9:  v = ZW'(733385);
            10: v = ZW'(366693);
            11: v = ZW'(183346);
            12: v = ZW'(91673);
            13: v = ZW'(45837);
            14: v = ZW'(22918);
            15: v = ZW'(11459);
            16: v = ZW'(5730);
            17: v = ZW'(2865);
            18: v = ZW'(1432);
            19: v = ZW'(716);
            20: v = ZW'(358);
            21: v = ZW'(179);
            22: v = ZW'(90);
            23: v = ZW'(45);
            24: v = ZW'(22);
            25: v = ZW'(11);
            26: v = ZW'(6);
            27: v = ZW'(3);
            28: v = ZW'(1);
            29: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/quaternion_to_euler.sv =====
// top level of the quaternion to yaw / pitch / roll converter
// depends on qte_pkg, qte_front, qte_queue, qte_back

// Takes one orientation quaternion per item (four signed 16-bit components with
// 14 fraction bits) and gives yaw, pitch and roll in centidegrees plus an
// invalid_norm flag that is set, with all angles zero, when the quaternion is zero.
// The block accepts one item every clock cycle unless the output stalls it, and
// has no state between items. An accepted item passes through the front part,
// the queue and the back part; the back part is set by the 32-step square root
// of the arcsine path followed by the 16-stage cordic units. The queue holds 4
// items, so the input keeps being taken for a while when the output is stalled.
// The back pipeline only moves while its result can leave, so results come out
// in order and are never lost.

module quaternion_to_euler (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // q_real [15:0], q_i [31:16], q_j [47:32], q_k [63:48]
    input  logic [63:0]                        s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // yaw_angle [15:0], pitch_angle [30:16], roll_angle [46:31], zero [47]
    output logic [qte_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // invalid_norm [0]
    output logic [0:0]                         m_tuser
);

    qte_pkg::front_item_t f_item, q_item;
    logic                 f_valid, f_ready, q_valid, q_ready;
    logic signed [qte_pkg::ANG_W-1:0]   yaw, roll;
    logic signed [qte_pkg::PITCH_W-1:0] pitch;
    logic                               bad;

    // front: products and sums, one item per cycle while the queue takes them
    qte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .q_real    (s_tdata[15:0]),
        .q_i       (s_tdata[31:16]),
        .q_j       (s_tdata[47:32]),
        .q_k       (s_tdata[63:48]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    // queue lets front and back stall independently
    qte_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // back: square root and arctangents
    qte_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (q_valid),
        .in_ready     (q_ready),
        .in_item      (q_item),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .yaw_angle    (yaw),
        .pitch_angle  (pitch),
        .roll_angle   (roll),
        .invalid_norm (bad)
    );

    assign m_tdata = {1'b0, roll, pitch, yaw};
    assign m_tuser = bad;

endmodule

// ===== design/qte_front.sv =====
// front part: component products and the product sums of the three angles
// depends on qte_pkg

module qte_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [15:0]    q_real,
    input  logic signed [15:0]    q_i,
    input  logic signed [15:0]    q_j,
    input  logic signed [15:0]    q_k,
    output logic                  out_valid,
    input  logic                  out_ready,
    output qte_pkg::front_item_t  out_item
);

    localparam int PW = qte_pkg::PW;
    localparam int SW = qte_pkg::SW;

    logic signed [PW-1:0] rr_reg, ii_reg, jj_reg, kk_reg;
    logic signed [PW-1:0] ij_reg, kr_reg, jk_reg, ir_reg, jr_reg, ik_reg;
    logic                 p_valid_reg, s_valid_reg;
    qte_pkg::front_item_t item_reg;
    logic                 adv;
    logic signed [SW-1:0] rr, ii, jj, kk;

    assign adv      = !s_valid_reg || out_ready;
    assign in_ready = adv;
    assign out_valid = s_valid_reg;
    assign out_item  = item_reg;

    assign rr = SW'(rr_reg);
    assign ii = SW'(ii_reg);
    assign jj = SW'(jj_reg);
    assign kk = SW'(kk_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg <= in_valid;
            s_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            rr_reg <= PW'(q_real) * PW'(q_real);
            ii_reg <= PW'(q_i) * PW'(q_i);
            jj_reg <= PW'(q_j) * PW'(q_j);
            kk_reg <= PW'(q_k) * PW'(q_k);
            ij_reg <= PW'(q_i) * PW'(q_j);
            kr_reg <= PW'(q_k) * PW'(q_real);
            jk_reg <= PW'(q_j) * PW'(q_k);
            ir_reg <= PW'(q_i) * PW'(q_real);
            jr_reg <= PW'(q_j) * PW'(q_real);
            ik_reg <= PW'(q_i) * PW'(q_k);
        end
        if (adv && p_valid_reg)
        begin
            item_reg.norm   <= rr + ii + jj + kk;
            item_reg.num    <= (SW'(jr_reg) - SW'(ik_reg)) <<< 1;
            item_reg.yaw_y  <= (SW'(ij_reg) + SW'(kr_reg)) <<< 1;
            item_reg.yaw_x  <= rr + ii - jj - kk;
            item_reg.roll_y <= (SW'(jk_reg) + SW'(ir_reg)) <<< 1;
            item_reg.roll_x <= rr - ii - jj + kk;
        end
    end

endmodule

// ===== design/qte_queue.sv =====
// short queue that decouples the front part from the back part
// depends on qte_pkg

module qte_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  qte_pkg::front_item_t  in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output qte_pkg::front_item_t  out_item
);

    localparam int QD  = qte_pkg::QDEPTH;
    localparam int QAW = qte_pkg::QAW;

    qte_pkg::front_item_t mem [QD];
    logic [QAW-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]         count_reg;
    logic                 push, pop;

    assign in_ready  = count_reg < (QAW+1)'(QD);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= in_item;
    end

endmodule

// ===== design/qte_cordic.sv =====
// pipelined vectoring cordic: four-quadrant arctangent in whole centidegrees
// depends on qte_pkg

module qte_cordic (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [qte_pkg::SW-1:0]        y_in,
    input  logic signed [qte_pkg::SW-1:0]        x_in,
    output logic signed [qte_pkg::ANG_W-1:0]     angle
);

    localparam int SW  = qte_pkg::SW;
    localparam int CXW = qte_pkg::CXW;
    localparam int ZW  = qte_pkg::ZW;
    localparam int NS  = qte_pkg::CSTAGES;
    localparam int SHW = ZW - qte_pkg::ZFRAC;
    localparam int ANG_W_L = qte_pkg::ANG_W;
    localparam logic signed [SHW-1:0] LIM = SHW'(qte_pkg::HALF_TURN_CD);

    logic signed [CXW-1:0] x_reg [NS+1];
    logic signed [CXW-1:0] y_reg [NS+1];
    logic signed [ZW-1:0]  z_reg [NS+1];
    logic                  zero_reg [NS+1];

    logic signed [CXW-1:0] xs, ys, x0, y0;
    logic signed [ZW-1:0]  z0, zr;
    logic signed [SHW-1:0] sh;

    // pre-rotation into the right half plane
    always_comb
    begin
        xs = CXW'(x_in);
        ys = CXW'(y_in);
        x0 = xs;
        y0 = ys;
        z0 = '0;
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                x0 = ys;
                y0 = -xs;
                z0 = qte_pkg::QUARTER_TURN;
            end
            else
            begin
                x0 = -ys;
                y0 = xs;
                z0 = -qte_pkg::QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x0;
            y_reg[0]    <= y0;
            z_reg[0]    <= z0;
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + qte_pkg::atan_entry(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - qte_pkg::atan_entry(i);
                end
            end
        end
    end

    // round half up to whole centidegrees, then clamp; a zero vector gives zero
    assign zr = z_reg[NS] + qte_pkg::HALF_LSB;
    assign sh = SHW'(zr >>> qte_pkg::ZFRAC);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_reg[NS])
                angle <= '0;
            else if (sh > LIM)
                angle <= ANG_W_L'(LIM);
            else if (sh < -LIM)
                angle <= ANG_W_L'(-LIM);
            else
                angle <= ANG_W_L'(sh);
        end
    end

endmodule

// ===== design/qte_back.sv =====
// back part: arcsine reduction, pipelined square root, three cordic units
// depends on qte_pkg and qte_cordic

module qte_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  qte_pkg::front_item_t                 in_item,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [qte_pkg::ANG_W-1:0]     yaw_angle,
    output logic signed [qte_pkg::PITCH_W-1:0]   pitch_angle,
    output logic signed [qte_pkg::ANG_W-1:0]     roll_angle,
    output logic                                 invalid_norm
);

    localparam int SW    = qte_pkg::SW;
    localparam int NW    = qte_pkg::NW;
    localparam int RADW  = qte_pkg::RADW;
    localparam int ISQ   = qte_pkg::ISQ_STEPS;
    localparam int DL    = qte_pkg::DL;
    localparam int LAT   = qte_pkg::BACK_LAT;
    localparam int ANG_W = qte_pkg::ANG_W;
    localparam int PW_W  = qte_pkg::PITCH_W;
    localparam logic signed [ANG_W-1:0] PLIM = ANG_W'(qte_pkg::QUARTER_TURN_CD);

    logic                 en;
    logic                 vld_reg [LAT];
    qte_pkg::side_t       sb_reg  [LAT];
    qte_pkg::side_t       sb_in;

    logic signed [NW-1:0]   nn_reg;
    logic signed [NW-1:0]   md_reg [DL];
    logic signed [SW-1:0]   yy_reg [DL];
    logic signed [SW-1:0]   yx_reg [DL];
    logic signed [SW-1:0]   ry_reg [DL];
    logic signed [SW-1:0]   rx_reg [DL];
    logic signed [RADW-1:0] nsq_reg, msq_reg, diff;
    logic [RADW-1:0]        sv_reg [ISQ+1];
    logic [RADW-1:0]        sr_reg [ISQ+1];

    logic [1:0]             shamt;
    logic signed [SW-1:0]   norm_sh, num_sh;
    logic signed [ANG_W-1:0] yaw_c, pitch_c, roll_c, pitch_sel;
    logic signed [SW-1:0]   pitch_y, pitch_x;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // classify the arcsine argument and pick the reduction shift
    always_comb
    begin
        sb_in.bad = in_item.norm == '0;
        if (in_item.num >= in_item.norm)
            sb_in.cls = qte_pkg::PC_POS;
        else if (in_item.num <= -in_item.norm)
            sb_in.cls = qte_pkg::PC_NEG;
        else
            sb_in.cls = qte_pkg::PC_MID;
        if (in_item.norm < (SW'(1) <<< (NW-1)))
            shamt = 2'd0;
        else if (in_item.norm < (SW'(1) <<< NW))
            shamt = 2'd1;
        else
            shamt = 2'd2;
        norm_sh = in_item.norm >>> shamt;
        num_sh  = in_item.num >>> shamt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= sb_in;
            for (int k = 1; k < LAT; k++)
                sb_reg[k] <= sb_reg[k-1];
            nn_reg    <= NW'(norm_sh);
            md_reg[0] <= NW'(num_sh);
            yy_reg[0] <= in_item.yaw_y;
            yx_reg[0] <= in_item.yaw_x;
            ry_reg[0] <= in_item.roll_y;
            rx_reg[0] <= in_item.roll_x;
            for (int k = 1; k < DL; k++)
            begin
                md_reg[k] <= md_reg[k-1];
                yy_reg[k] <= yy_reg[k-1];
                yx_reg[k] <= yx_reg[k-1];
                ry_reg[k] <= ry_reg[k-1];
                rx_reg[k] <= rx_reg[k-1];
            end
            nsq_reg   <= RADW'(nn_reg) * RADW'(nn_reg);
            msq_reg   <= RADW'(md_reg[0]) * RADW'(md_reg[0]);
            sv_reg[0] <= (diff < 0) ? '0 : RADW'(diff);
            sr_reg[0] <= '0;
        end
    end

    assign diff = nsq_reg - msq_reg;

    // floor square root, one result bit per stage
    for (genvar k = 0; k < ISQ; k++)
    begin : g_isqrt
        localparam logic [RADW-1:0] BIT = RADW'(1) << (2 * (ISQ - 1 - k));
        logic [RADW-1:0] trial;
        assign trial = sr_reg[k] + BIT;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (sv_reg[k] >= trial)
                begin
                    sv_reg[k+1] <= sv_reg[k] - trial;
                    sr_reg[k+1] <= (sr_reg[k] >> 1) + BIT;
                end
                else
                begin
                    sv_reg[k+1] <= sv_reg[k];
                    sr_reg[k+1] <= sr_reg[k] >> 1;
                end
            end
        end
    end

    assign pitch_y = SW'(md_reg[DL-1]);
    assign pitch_x = SW'(sr_reg[ISQ][NW-1:0]);

    qte_cordic u_yaw (
        .clk   (clk),
        .en    (en),
        .y_in  (yy_reg[DL-1]),
        .x_in  (yx_reg[DL-1]),
        .angle (yaw_c)
    );

    qte_cordic u_pitch (
        .clk   (clk),
        .en    (en),
        .y_in  (pitch_y),
        .x_in  (pitch_x),
        .angle (pitch_c)
    );

    qte_cordic u_roll (
        .clk   (clk),
        .en    (en),
        .y_in  (ry_reg[DL-1]),
        .x_in  (rx_reg[DL-1]),
        .angle (roll_c)
    );

    always_comb
    begin
        case (sb_reg[LAT-1].cls)
            qte_pkg::PC_POS: pitch_sel = PLIM;
            qte_pkg::PC_NEG: pitch_sel = -PLIM;
            default:
            begin
                if (pitch_c > PLIM)
                    pitch_sel = PLIM;
                else if (pitch_c < -PLIM)
                    pitch_sel = -PLIM;
                else
                    pitch_sel = pitch_c;
            end
        endcase
    end

    assign out_valid    = vld_reg[LAT-1];
    assign invalid_norm = sb_reg[LAT-1].bad;
    assign yaw_angle    = sb_reg[LAT-1].bad ? '0 : yaw_c;
    assign roll_angle   = sb_reg[LAT-1].bad ? '0 : roll_c;
    assign pitch_angle  = sb_reg[LAT-1].bad ? '0 : PW_W'(pitch_sel);

endmodule

// ===== design/qte_checker.sv =====
// port-level checks of the quaternion to euler block, bound to the top level
// depends on quaternion_to_euler

module qte_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // zero quaternion gives zero angles
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[46:0] == 47'd0)
        else $error("invalid item with nonzero angles");

    a_yaw_rng: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[15:0]) <= 16'sd18000 &&
                     $signed(m_tdata[15:0]) >= -16'sd18000 &&
                     $signed(m_tdata[46:31]) <= 16'sd18000 &&
                     $signed(m_tdata[46:31]) >= -16'sd18000)
        else $error("yaw or roll out of range");

    a_pitch_rng: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[30:16]) <= 15'sd9000 &&
                     $signed(m_tdata[30:16]) >= -15'sd9000 && !m_tdata[47])
        else $error("pitch out of range");

endmodule

bind quaternion_to_euler qte_checker u_qte_checker (.*);

// ===== dv/quaternion_to_euler_tb.sv =====
// self-checking testbench of the quaternion to yaw / pitch / roll converter
// depends on qte_pkg and quaternion_to_euler; holds its own angle predictor

`timescale 1ns / 1ps

class euler_scoreboard;
    logic [47:0] angle_q[$];
    logic        flag_q[$];
    int          errors = 0;

    // remember the angles due for an accepted quaternion
    function void note_input(logic [47:0] angles, logic flag);
        angle_q.push_back(angles);
        flag_q.push_back(flag);
    endfunction

    // compare one accepted result with the oldest expected one
    function void check_result(logic [47:0] data, logic flag);
        logic [47:0] e;
        logic        ef;
        if (angle_q.size() == 0)
        begin
            $error("result with nothing expected: %h", data);
            errors++;
            return;
        end
        e = angle_q.pop_front();
        ef = flag_q.pop_front();
        if (data[15:0] !== e[15:0])
        begin
            $error("yaw_angle expected %0d actual %0d", $signed(e[15:0]), $signed(data[15:0]));
            errors++;
        end
        if (data[30:16] !== e[30:16])
        begin
            $error("pitch_angle expected %0d actual %0d", $signed(e[30:16]),
                $signed(data[30:16]));
            errors++;
        end
        if (data[46:31] !== e[46:31])
        begin
            $error("roll_angle expected %0d actual %0d", $signed(e[46:31]),
                $signed(data[46:31]));
            errors++;
        end
        if (data[47] !== 1'b0)
        begin
            $error("pad bit expected 0 actual %b", data[47]);
            errors++;
        end
        if (flag !== ef)
        begin
            $error("invalid_norm expected %b actual %b", ef, flag);
            errors++;
        end
    endfunction
endclass

module quaternion_to_euler_tb;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [qte_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [0:0]  m_tuser;

    euler_scoreboard sb = new();
    bit          sending_done = 0;
    int          stall_hold = 0;     // long output hold-off, counted by the receiver

    quaternion_to_euler DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    // vectoring cordic arctangent, whole centidegrees
    function automatic longint atan2_cd(longint y, longint x);
        longint z, t, dx, dy;
        if (x == 0 && y == 0)
            return 0;
        z = 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 64'(qte_pkg::QUARTER_TURN);
            end
            else
            begin
                x = -y; y = t; z = -64'(qte_pkg::QUARTER_TURN);
            end
        end
        for (int i = 0; i < qte_pkg::CSTAGES; i++)
        begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (y >= 0)
            begin
                x += dx; y -= dy; z += 64'(qte_pkg::atan_entry(i));
            end
            else
            begin
                x -= dx; y += dy; z -= 64'(qte_pkg::atan_entry(i));
            end
        end
        z = fshr(z + 32768, 16);
        if (z > 18000) z = 18000;
        if (z < -18000) z = -18000;
        return z;
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0)
        begin
            if (v >= res + bit_v)
            begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end
            else
                res >>= 1;
            bit_v >>= 2;
        end
        return res;
    endfunction

    // expected yaw / pitch / roll word and flag for one quaternion
    task automatic predict_angles(input logic [63:0] q, output logic [47:0] angles,
        output logic flag);
        longint r, a, b, c, sr, si, sj, sk, norm, num, yaw, pitch, roll, nn, mm, c2;
        int s;
        r = longint'($signed(q[15:0]));
        a = longint'($signed(q[31:16]));
        b = longint'($signed(q[47:32]));
        c = longint'($signed(q[63:48]));
        sr = r * r; si = a * a; sj = b * b; sk = c * c;
        norm = sr + si + sj + sk;
        yaw = 0; pitch = 0; roll = 0; flag = 0;
        if (norm == 0)
            flag = 1;
        else
        begin
            num = 2 * (b * r - a * c);
            yaw = atan2_cd(2 * (a * b + c * r), sr + si - sj - sk);
            roll = atan2_cd(2 * (b * c + a * r), sr - si - sj + sk);
            if (num >= norm)
                pitch = 9000;
            else if (num <= -norm)
                pitch = -9000;
            else
            begin
                s = 0;
                while ((norm >> s) >= (64'd1 << 31)) s++;
                nn = fshr(norm, s);
                mm = fshr(num, s);
                c2 = nn * nn - mm * mm;
                if (c2 < 0) c2 = 0;
                pitch = atan2_cd(mm, floor_sqrt(c2));
                if (pitch > 9000) pitch = 9000;
                if (pitch < -9000) pitch = -9000;
            end
        end
        angles = {1'b0, roll[15:0], pitch[14:0], yaw[15:0]};
    endtask

    // offer one quaternion and wait for it to be taken
    task automatic send_quat(input logic [63:0] q);
        logic [47:0] e;
        logic        f;
        predict_angles(q, e, f);
        s_tdata <= q;
        s_tvalid <= 1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input(e, f);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0)
        begin
            s_tvalid <= 0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [15:0] rand_comp(input int mode);
        case (mode)
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // components within plus or minus one dominate, with extremes, tiny and full-range values mixed in
    function automatic logic [63:0] rand_quat();
        logic [63:0] q;
        int mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 4; k++)
            if (mode < 6)
                q[16*k +: 16] = 16'(int'($urandom_range(0, 32768)) - 16384);
            else
                q[16*k +: 16] = rand_comp($urandom_range(0, 5));
        return q;
    endfunction

    // receiver: random stalls, bursts of readiness, and one long hold-off
    initial
    begin
        int pat;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser[0]);
            if (stall_hold > 0)
            begin
                stall_hold--;
                m_tready <= 0;
            end
            else
            begin
                pat = $urandom_range(0, 15);
                m_tready <= (pat < 11) || sending_done;
            end
        end
    end

    initial
    begin
        logic [63:0] dq[$];
        int burst;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: zero, extremes, axes, pitch clamps, degenerate atan2 operands
        dq.push_back(64'h0);
        dq.push_back({4{16'h8000}});
        dq.push_back({4{16'h7fff}});
        dq.push_back({16'h0, 16'h0, 16'h0, 16'h4000});
        dq.push_back({16'h0, 16'h0, 16'h4000, 16'h0});
        dq.push_back({16'h0, 16'h4000, 16'h0, 16'h0});
        dq.push_back({16'h4000, 16'h0, 16'h0, 16'h0});
        dq.push_back({16'h0, 16'h2d41, 16'h0, 16'h2d41});
        dq.push_back({16'h0, 16'h2d41, 16'h0, 16'hd2bf});
        dq.push_back({16'h0, 16'h0, 16'h4000, 16'h4000});
        dq.push_back({16'h0, 16'h0, 16'h0, 16'hc000});
        dq.push_back({16'h8000, 16'h0, 16'h0, 16'h0});
        dq.push_back({16'h0, 16'h0, 16'h0, 16'h0001});
        dq.push_back({16'hffff, 16'hffff, 16'hffff, 16'hffff});
        dq.push_back({16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
        dq.push_back({16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
        dq.push_back({16'h2000, 16'h2000, 16'h2000, 16'h2000});
        dq.push_back({16'he000, 16'h2000, 16'he000, 16'h2000});
        foreach (dq[n])
            send_quat(dq[n]);

        // random part in bursts with gaps; long output hold-off midway
        for (int n = 0; n < 1650; )
        begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < 1650; b++, n++)
            begin
                if (n == 600)
                    stall_hold = 300;
                send_quat(rand_quat());
            end
            idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
        end
        s_tvalid <= 0;
        sending_done = 1;

        while (sb.angle_q.size() != 0) @(posedge clk);
        repeat (qte_pkg::BACK_LAT + 20) @(posedge clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end
endmodule

// ===== quaternion_to_euler.f =====
design/qte_pkg.sv
design/qte_front.sv
design/qte_queue.sv
design/qte_cordic.sv
design/qte_back.sv
design/quaternion_to_euler.sv
design/qte_checker.sv
dv/quaternion_to_euler_tb.sv
